FILE: src/separable_box_blur_assert.svh
// Assertion macros used by the checker file.
`ifndef SEPARABLE_BOX_BLUR_ASSERT_SVH
`define SEPARABLE_BOX_BLUR_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SBB_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SBB_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: src/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared constants, types and the reciprocal table for the box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package sbb_pkg;

    localparam int MAX_RADIUS  = 15;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int TAPS_MAX    = 2 * MAX_RADIUS + 1;

    localparam int PIX_W       = 8;
    localparam int RAD_W       = 4;
    localparam int DIM_W       = 11;
    localparam int SUM_W       = 13;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int SLOT_W      = $clog2(TAPS_MAX);
    localparam int LS_DEPTH    = TAPS_MAX * MAX_WIDTH;
    localparam int LS_AW       = SLOT_W + COL_W;

    // Exact floor division of values below 2^14 by 2R+1
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 20;
    localparam int MEAN_IN_W   = SUM_W + 1;
    localparam int PROD_W      = MEAN_IN_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_RADIUS = 2'd0;
    localparam cfg_index_t CFG_WIDTH  = 2'd1;
    localparam cfg_index_t CFG_HEIGHT = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HMEAN = 5'b00010,
        S_UPD   = 5'b00100,
        S_VMEAN = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    // ceil(2^19 / (2r+1))
    function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
        logic [RECIP_W-1:0] m;
        begin
            case (r)
                4'd0:    m = 20'd524288;
                4'd1:    m = 20'd174763;
                4'd2:    m = 20'd104858;
                4'd3:    m = 20'd74899;
                4'd4:    m = 20'd58255;
                4'd5:    m = 20'd47663;
                4'd6:    m = 20'd40330;
                4'd7:    m = 20'd34953;
                4'd8:    m = 20'd30841;
                4'd9:    m = 20'd27595;
                4'd10:   m = 20'd24967;
                4'd11:   m = 20'd22796;
                4'd12:   m = 20'd20972;
                4'd13:   m = 20'd19419;
                4'd14:   m = 20'd18079;
                default: m = 20'd16913;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/sbb_ram.sv
// ----------------------------------------------------------------------------
// sbb_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: src/sbb_mean.sv
// ----------------------------------------------------------------------------
// sbb_mean
// Rounded box mean (sum+R)/(2R+1) by reciprocal multiply, saturated to 255.
// ----------------------------------------------------------------------------
`default_nettype none

module sbb_mean (
    input  wire logic                        clk,
    input  wire logic [sbb_pkg::SUM_W-1:0]   sum,
    input  wire logic [sbb_pkg::RAD_W-1:0]   radius,
    output logic      [sbb_pkg::PIX_W-1:0]   mean
);
    import sbb_pkg::*;

    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    logic [MEAN_IN_W-1:0] biased;
    logic [QUOT_W-1:0]    quot;

    always_comb
    begin
        biased    = MEAN_IN_W'(sum) + MEAN_IN_W'(radius);
        prod_next = PROD_W'(biased) * PROD_W'(recip(radius));
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // drop the fraction, clamp to a pixel
    always_comb
    begin
        quot = prod_reg[PROD_W-1:RECIP_SHIFT];
        mean = (quot > QUOT_W'(255)) ? PIX_W'(255) : quot[PIX_W-1:0];
    end

endmodule

`default_nettype wire

FILE: src/separable_box_blur.sv
// ----------------------------------------------------------------------------
// separable_box_blur
// Two-pass separable box blur over a raster window of 8-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid/in_ready) carry one window pixel each in raster
//   order; frame_start marks the first pixel of a window. The window is the
//   output region widened by radius on every side.
//   Output requests (out_valid/out_ready) carry one blurred pixel with
//   row_end and frame_end flags, in raster order of the output region.
//   Configuration requests (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always taken: index 0 radius, 1 region width, 2 region height.
// Timing:
//   A pixel that yields no horizontal mean is handled in S_IDLE alone. One
//   inside the horizontal span also passes S_HMEAN and S_UPD (read, update
//   line store and column sum RAMs); one that also produces a result passes
//   S_VMEAN and S_OUT too, as the reciprocal multiplier is shared and each RAM
//   has a single port. The result enters the output register in S_OUT.
// Reset:
//   Counters and sums clear; the first pixel is window position (0,0).
//   No clearing pass: column sums read as zero until written this frame.
// Stall:
//   The output register holds a result while out_ready is low; the next
//   pixel is still taken and waits only at its own output step.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_box_blur (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [sbb_pkg::DIM_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sbb_pkg::PIX_W-1:0]   pixel,
    input  wire logic                        frame_start,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [sbb_pkg::PIX_W-1:0]   blurred,
    output logic                             row_end,
    output logic                             frame_end
);
    import sbb_pkg::*;

    // configuration
    logic [RAD_W-1:0] radius_reg, radius_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;

    // frame progress
    state_t            state_reg, state_next;
    logic [DIM_W-1:0]  cc_reg, cc_next;
    logic [DIM_W-1:0]  rc_reg, rc_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [DIM_W-1:0]  hi_reg, hi_next;

    // horizontal pass
    logic [PIX_W-1:0]  win_reg  [TAPS_MAX];
    logic [PIX_W-1:0]  win_next [TAPS_MAX];
    logic [SUM_W-1:0]  hsum_reg, hsum_next;

    // per-item context
    logic [COL_W-1:0]  oc_reg, oc_next;
    logic [SLOT_W-1:0] islot_reg, islot_next;
    logic              old_ok_reg, old_ok_next;
    logic              col_ok_reg, col_ok_next;
    logic              emit_reg, emit_next;
    logic              rend_reg, rend_next;
    logic              fend_reg, fend_next;
    logic [SUM_W-1:0]  colnew_reg, colnew_next;

    // output register
    logic              ov_reg, ov_next;
    logic [PIX_W-1:0]  ob_reg, ob_next;
    logic              ore_reg, ore_next;
    logic              ofe_reg, ofe_next;

    // derived
    logic [DIM_W-1:0]  w_eff, h_eff, rowlen, rows, two_r;
    logic [SLOT_W-1:0] taps;
    logic [DIM_W-1:0]  e_cc, e_rc, e_hi, oc_full, cc_inc;
    logic [SLOT_W-1:0] e_slot;
    logic              halted, in_span, take;
    logic [PIX_W-1:0]  leaving;
    logic [SUM_W-1:0]  hbase;

    // memories and mean unit
    logic [PIX_W-1:0]  ls_rdata, mean;
    logic [SUM_W-1:0]  cs_rdata, mean_in, col_old;
    logic [PIX_W-1:0]  line_old;
    logic              mem_we;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign blurred   = ob_reg;
    assign row_end   = ore_reg;
    assign frame_end = ofe_reg;

    always_comb
    begin
        w_eff = (width_reg == '0) ? DIM_W'(1)
              : (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
        h_eff = (height_reg == '0) ? DIM_W'(1)
              : (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
        two_r  = DIM_W'({radius_reg, 1'b0});
        taps   = SLOT_W'({radius_reg, 1'b1});
        rowlen = w_eff + two_r;
        rows   = h_eff + two_r;
    end

    // configuration writes
    always_comb
    begin
        radius_next = radius_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RADIUS: radius_next = cfg_data[RAD_W-1:0];
                CFG_WIDTH:  width_next  = cfg_data;
                CFG_HEIGHT: height_next = cfg_data;
                default:    ;
            endcase
        end
    end

    // accept step: frame clear, window shift, running row sum, counters
    always_comb
    begin
        take    = in_valid && (state_reg == S_IDLE);
        e_cc    = frame_start ? '0 : cc_reg;
        e_rc    = frame_start ? '0 : rc_reg;
        e_hi    = frame_start ? '0 : hi_reg;
        e_slot  = frame_start ? '0 : slot_reg;
        halted  = (e_rc >= rows);
        leaving = (e_cc == '0) ? '0 : win_reg[two_r[SLOT_W-1:0]];
        hbase   = (e_cc == '0) ? '0 : hsum_reg;
        oc_full = e_cc - two_r;
        in_span = (e_cc >= two_r) && (oc_full < w_eff);
        cc_inc  = e_cc + DIM_W'(1);

        cc_next     = cc_reg;
        rc_next     = rc_reg;
        slot_next   = slot_reg;
        hi_next     = hi_reg;
        hsum_next   = hsum_reg;
        win_next    = win_reg;
        oc_next     = oc_reg;
        islot_next  = islot_reg;
        old_ok_next = old_ok_reg;
        col_ok_next = col_ok_reg;
        emit_next   = emit_reg;
        rend_next   = rend_reg;
        fend_next   = fend_reg;

        if (take && !halted)
        begin
            hsum_next = hbase + SUM_W'(pixel) - SUM_W'(leaving);
            for (int i = TAPS_MAX - 1; i > 0; i--)
            begin
                win_next[i] = (e_cc == '0) ? '0 : win_reg[i-1];
            end
            win_next[0] = pixel;

            oc_next     = oc_full[COL_W-1:0];
            islot_next  = e_slot;
            old_ok_next = (e_rc >= DIM_W'(taps));
            col_ok_next = (oc_full < e_hi);
            emit_next   = (e_rc >= two_r);
            rend_next   = (oc_full == w_eff - DIM_W'(1));
            fend_next   = (oc_full == w_eff - DIM_W'(1)) && (e_rc == rows - DIM_W'(1));

            hi_next = e_hi;
            if (in_span && (oc_full >= e_hi))
            begin
                hi_next = oc_full + DIM_W'(1);
            end

            if (cc_inc >= rowlen)
            begin
                cc_next   = '0;
                rc_next   = e_rc + DIM_W'(1);
                slot_next = (e_slot + SLOT_W'(1) >= taps) ? '0 : e_slot + SLOT_W'(1);
            end
            else
            begin
                cc_next   = cc_inc;
                rc_next   = e_rc;
                slot_next = e_slot;
            end
        end
    end

    // sequencer and vertical update
    always_comb
    begin
        state_next  = state_reg;
        mem_we      = 1'b0;
        line_old    = old_ok_reg ? ls_rdata : '0;
        col_old     = col_ok_reg ? cs_rdata : '0;
        colnew_next = colnew_reg;
        mean_in     = (state_reg == S_HMEAN) ? hsum_reg : colnew_reg;
        ov_next     = ov_reg && !out_ready;
        ob_next     = ob_reg;
        ore_next    = ore_reg;
        ofe_next    = ofe_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take && !halted && in_span)
                begin
                    state_next = S_HMEAN;
                end
            end
            S_HMEAN:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                mem_we      = 1'b1;
                colnew_next = col_old + SUM_W'(mean) - SUM_W'(line_old);
                state_next  = emit_reg ? S_VMEAN : S_IDLE;
            end
            S_VMEAN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register frees
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ob_next    = mean;
                    ore_next   = rend_reg;
                    ofe_next   = fend_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    sbb_mean u_mean (
        .clk    (clk),
        .sum    (mean_in),
        .radius (radius_reg),
        .mean   (mean)
    );

    sbb_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_line_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  ({islot_reg, oc_reg}),
        .wdata (mean),
        .rdata (ls_rdata)
    );

    sbb_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_col_sums (
        .clk   (clk),
        .we    (mem_we),
        .addr  (oc_reg),
        .wdata (colnew_next),
        .rdata (cs_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_W'(1);
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
            state_reg  <= S_IDLE;
            cc_reg     <= '0;
            rc_reg     <= '0;
            slot_reg   <= '0;
            hi_reg     <= '0;
            hsum_reg   <= '0;
            ov_reg     <= 1'b0;
            for (int i = 0; i < TAPS_MAX; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            radius_reg <= radius_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            state_reg  <= state_next;
            cc_reg     <= cc_next;
            rc_reg     <= rc_next;
            slot_reg   <= slot_next;
            hi_reg     <= hi_next;
            hsum_reg   <= hsum_next;
            ov_reg     <= ov_next;
            win_reg    <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oc_reg     <= oc_next;
        islot_reg  <= islot_next;
        old_ok_reg <= old_ok_next;
        col_ok_reg <= col_ok_next;
        emit_reg   <= emit_next;
        rend_reg   <= rend_next;
        fend_reg   <= fend_next;
        colnew_reg <= colnew_next;
        ob_reg     <= ob_next;
        ore_reg    <= ore_next;
        ofe_reg    <= ofe_next;
    end

endmodule

`default_nettype wire

FILE: src/sbb_checker.sv
// ----------------------------------------------------------------------------
// sbb_checker
// Port-level checks on the blurred pixel stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "separable_box_blur_assert.svh"

module sbb_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [sbb_pkg::PIX_W-1:0]   blurred,
    input  wire logic                        row_end,
    input  wire logic                        frame_end
);
    import sbb_pkg::*;

    `SBB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `SBB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(blurred) && $stable(row_end) && $stable(frame_end), "result changed while stalled")
    `SBB_ASSERT_NOW(a_frame_row, out_valid && frame_end, row_end, "frame end without row end")
    `SBB_ASSERT_NOW(a_reset_empty, $rose(rst_n), !out_valid, "result present after reset")

endmodule

bind separable_box_blur sbb_checker u_sbb_checker (.*);

`default_nettype wire
